// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DDSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DDSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ddsp_pkg.sv
// Package: field widths, register indexes, shape codes and shared types of the sampler.
`default_nettype none
package ddsp_pkg;

	localparam int FRAC_W   = 32;
	localparam int DEMAND_W = 8;
	localparam int MODE_W   = 2;
	localparam int SIZE_W   = 8;
	localparam int IDX_W    = 1;

	// register indexes of the write port
	localparam logic [IDX_W-1:0] REG_SHAPE_MODE = 1'b0;
	localparam logic [IDX_W-1:0] REG_TABLE_SIZE = 1'b1;

	// shape codes; the unused code builds the uniform table
	localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RAMP    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRI     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_RESET = MODE_UNIFORM;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd100;

	typedef struct packed {
		logic [MODE_W-1:0] shape_mode;
		logic [SIZE_W-1:0] table_size;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_HOLD
	} srch_state_t;

endpackage
`default_nettype wire

// File: hdl/ddsp_channels.sv
// Valid/ready channel interfaces for the fraction input and the demand output.
`default_nettype none
interface ddsp_frac_if;
	logic                       valid;
	logic                       ready;
	logic [ddsp_pkg::FRAC_W-1:0] uniform_fraction;

	modport source (output valid, output uniform_fraction, input ready);
	modport sink (input valid, input uniform_fraction, output ready);
endinterface

interface ddsp_demand_if;
	logic                         valid;
	logic                         ready;
	logic [ddsp_pkg::DEMAND_W-1:0] demand_value;

	modport source (output valid, output demand_value, input ready);
	modport sink (input valid, input demand_value, output ready);
endinterface
`default_nettype wire

// File: hdl/ddsp_table_mem.sv
// Cumulative count table: one write port, one read port with registered data.
`default_nettype none
module ddsp_table_mem #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire                                                     clk,
	input  wire                                                     we,
	input  wire  [$clog2(MAX_ENTRIES)-1:0]                          waddr,
	input  wire  [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      wdata,
	input  wire  [$clog2(MAX_ENTRIES)-1:0]                          raddr,
	output logic [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      rdata
);
	localparam int CW = $clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1);

	logic [CW-1:0] mem_q [MAX_ENTRIES];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data registered for the next cycle
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/ddsp_builder.sv
// Table builder: writes one cumulative count per cycle after reset or a register write.
`default_nettype none
module ddsp_builder #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire                                                     clk,
	input  wire                                                     arst_n,
	input  wire                                                     start,
	input  ddsp_pkg::cfg_regs_t                                     cfg,
	output logic                                                    busy,
	output logic [$clog2(MAX_ENTRIES+1)-1:0]                        n_used,
	output logic [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      total,
	output logic                                                    we,
	output logic [$clog2(MAX_ENTRIES)-1:0]                          waddr,
	output logic [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      wdata
);
	import ddsp_pkg::*;

	localparam int NW = $clog2(MAX_ENTRIES+1);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1);
	localparam int SW = (NW > SIZE_W) ? NW : SIZE_W;
	localparam int PW = 2*NW + 1;

	logic [SW-1:0] size_ext;
	logic [NW-1:0] n_w;
	logic [PW-1:0] n_ext;
	logic [PW-1:0] ramp_prod;
	logic [PW-1:0] tri_prod;
	logic [CW-1:0] total_d;
	logic [NW-1:0] half_n;
	logic [CW-1:0] count_d;
	logic [CW-1:0] i_ext;

	logic          busy_q;
	logic [NW-1:0] i_q;
	logic [CW-1:0] acc_q;
	logic [CW-1:0] total_q;

	// saturate the size to the table depth
	always_comb begin
		size_ext = SW'(cfg.table_size);
		if (size_ext > SW'(MAX_ENTRIES)) begin
			n_w = NW'(MAX_ENTRIES);
		end else begin
			n_w = NW'(size_ext);
		end
	end

	// total weight for the selected shape
	always_comb begin
		n_ext     = PW'(n_w);
		ramp_prod = n_ext * (n_ext + PW'(1));
		tri_prod  = n_ext * n_ext;
		case (cfg.shape_mode)
			MODE_RAMP: total_d = CW'(ramp_prod >> 1);
			MODE_TRI:  total_d = CW'(tri_prod >> 2);
			default:   total_d = CW'(n_w);
		endcase
	end

	// count of the entry being written
	always_comb begin
		half_n = n_w >> 1;
		i_ext  = CW'(i_q);
		case (cfg.shape_mode)
			MODE_RAMP: count_d = acc_q + i_ext + CW'(1);
			MODE_TRI: begin
				if (i_q == '0) begin
					count_d = '0;
				end else if (i_q < half_n) begin
					count_d = acc_q + i_ext;
				end else begin
					count_d = acc_q + CW'(n_w - i_q);
				end
			end
			default:   count_d = i_ext + CW'(1);
		endcase
	end

	// build sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			i_q     <= '0;
			acc_q   <= '0;
			total_q <= '0;
		end else if (start) begin
			busy_q  <= (n_w != '0);
			i_q     <= '0;
			acc_q   <= '0;
			total_q <= total_d;
		end else if (busy_q) begin
			acc_q <= count_d;
			i_q   <= i_q + NW'(1);
			if (i_q + NW'(1) == n_w) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy   = busy_q;
	assign n_used = n_w;
	assign total  = total_q;
	assign we     = busy_q;
	assign waddr  = i_q[AW-1:0];
	assign wdata  = count_d;
endmodule
`default_nettype wire

// File: hdl/ddsp_search.sv
// Search engine: scales the fraction, walks the table one entry a cycle, holds the result word.
`default_nettype none
module ddsp_search #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire                                                     clk,
	input  wire                                                     arst_n,
	ddsp_frac_if.sink                                               frac_in,
	ddsp_demand_if.source                                           demand_out,
	input  wire                                                     hold_off,
	input  wire  [$clog2(MAX_ENTRIES+1)-1:0]                        n_used,
	input  wire  [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      total,
	output logic [$clog2(MAX_ENTRIES)-1:0]                          raddr,
	input  wire  [$clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1)-1:0]      rdata
);
	import ddsp_pkg::*;

	localparam int NW = $clog2(MAX_ENTRIES+1);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1);
	localparam int XW = FRAC_W + CW;

	srch_state_t      state_q, state_d;
	logic [FRAC_W-1:0] u_q;
	logic [CW-1:0]     hi_q;
	logic [NW-1:0]     k_q;
	logic              out_valid_q;
	logic [DEMAND_W-1:0] out_data_q;

	logic          accept;
	logic [XW-1:0] prod;
	logic [NW-1:0] k_inc;
	logic          pass;
	logic          out_load;
	logic [15:0]   k_ext;

	// scaled fraction: integer part of u * total / 2^32
	assign prod  = XW'(u_q) * XW'(total);
	assign k_inc = k_q + NW'(1);
	assign pass  = (rdata <= hi_q);
	assign k_ext = 16'(k_q);

	// next state and handshakes
	always_comb begin
		state_d       = state_q;
		frac_in.ready = (state_q == ST_IDLE) && !hold_off;
		accept        = frac_in.valid && frac_in.ready;
		out_load      = (state_q == ST_HOLD) && (!out_valid_q || demand_out.ready);
		raddr         = (state_q == ST_CMP) ? k_inc[AW-1:0] : '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = (n_used == '0) ? ST_HOLD : ST_CMP;
			end
			ST_CMP: begin
				if (!pass || k_inc == n_used) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, entry counter and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				k_q <= '0;
			end else if (state_q == ST_CMP && pass) begin
				k_q <= k_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (demand_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			u_q <= frac_in.uniform_fraction;
		end
		if (state_q == ST_MUL) begin
			hi_q <= prod[XW-1:FRAC_W];
		end
		if (out_load) begin
			out_data_q <= k_ext[DEMAND_W-1:0];
		end
	end

	assign demand_out.valid        = out_valid_q;
	assign demand_out.demand_value = out_data_q;
endmodule
`default_nettype wire

// File: hdl/discrete_demand_sampler_top.sv
// A word is accepted while idle, scaled, and walked against the table until an entry exceeds
// it or the table ends; its demand value then goes into the output register. Throughput: one
// word at a time; the table walk reads one entry per cycle from the RAM.
// Next word is taken once the result has moved into the output register.
// Reset and each register write rebuild the table, with the input held off until it is done.
// Reset values: uniform shape, table size 100 (saturated to MAX_ENTRIES).
`default_nettype none
`include "assert_macros.svh"
module discrete_demand_sampler_top #(
	parameter int MAX_ENTRIES = 128
) (
	input  wire                              clk,
	input  wire                              arst_n,
	ddsp_frac_if.sink                        frac_in,
	ddsp_demand_if.source                    demand_out,
	input  wire                              write_en,
	input  wire  [ddsp_pkg::IDX_W-1:0]       reg_index,
	input  wire  [ddsp_pkg::SIZE_W-1:0]      write_data
);
	import ddsp_pkg::*;

	localparam int NW = $clog2(MAX_ENTRIES+1);
	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES*(MAX_ENTRIES+1)/2+1);

	cfg_regs_t     cfg_q;
	logic          start_q;
	logic          build_busy;
	logic [NW-1:0] n_used;
	logic [CW-1:0] total;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] mem_rdata;

	// config registers; any write restarts the table build
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shape_mode <= MODE_RESET;
			cfg_q.table_size <= SIZE_RESET;
			start_q          <= 1'b1;
		end else begin
			start_q <= write_en;
			if (write_en) begin
				case (reg_index)
					REG_SHAPE_MODE: cfg_q.shape_mode <= write_data[MODE_W-1:0];
					REG_TABLE_SIZE: cfg_q.table_size <= write_data;
					default: ;
				endcase
			end
		end
	end

	ddsp_builder #(.MAX_ENTRIES(MAX_ENTRIES)) u_builder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.cfg    (cfg_q),
		.busy   (build_busy),
		.n_used (n_used),
		.total  (total),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata)
	);

	ddsp_table_mem #(.MAX_ENTRIES(MAX_ENTRIES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ddsp_search #(.MAX_ENTRIES(MAX_ENTRIES)) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.frac_in    (frac_in),
		.demand_out (demand_out),
		.hold_off   (build_busy || start_q),
		.n_used     (n_used),
		.total      (total),
		.raddr      (mem_raddr),
		.rdata      (mem_rdata)
	);

	// checks
	`DDSP_ASSERT_NOW(a_build_holds_input, clk, arst_n, build_busy, !frac_in.ready, "word accepted during table build")
	`DDSP_ASSERT_NEXT(a_write_holds_input, clk, arst_n, write_en, !frac_in.ready, "input ready right after a register write")
	`DDSP_ASSERT_NEXT(a_one_in_flight, clk, arst_n, frac_in.valid && frac_in.ready, !frac_in.ready, "second word taken while one is in flight")
	`DDSP_ASSERT_NOW(a_demand_in_range, clk, arst_n, demand_out.valid, 16'(demand_out.demand_value) <= 16'(n_used), "demand value above table size")
endmodule
`default_nettype wire

// File: sim/discrete_demand_sampler_top_test.sv
// Self-checking test of discrete_demand_sampler_top: table predictor, random words, stalls.
`default_nettype none

// Copy of the cumulative table, with a queue of demand values still to come back.
class demand_table_checker;
	localparam int MAX_ENTRIES = 128;

	typedef struct {
		logic [ddsp_pkg::FRAC_W-1:0]   fraction;
		logic [ddsp_pkg::DEMAND_W-1:0] demand;
	} demand_pending_t;

	logic [ddsp_pkg::MODE_W-1:0] shape;
	logic [ddsp_pkg::SIZE_W-1:0] size;
	int unsigned                 counts [MAX_ENTRIES];
	int unsigned                 total;
	int unsigned                 used;
	demand_pending_t             awaited [$];
	int unsigned                 mismatches;
	int unsigned                 words_in;
	int unsigned                 words_out;

	function new();
		shape      = ddsp_pkg::MODE_RESET;
		size       = ddsp_pkg::SIZE_RESET;
		mismatches = 0;
		words_in   = 0;
		words_out  = 0;
		rebuild_counts();
	endfunction

	// Table rebuild, same walk as the hardware's build pass
	function void rebuild_counts();
		int unsigned n;
		int unsigned acc;
		n   = (size > MAX_ENTRIES) ? MAX_ENTRIES : size;
		used = n;
		acc = 0;
		foreach (counts[j])
			counts[j] = 0;
		case (shape)
			ddsp_pkg::MODE_RAMP: begin
				total = n * (n + 1) / 2;
				for (int unsigned i = 0; i < n; i++) begin
					acc += i + 1;
					counts[i] = acc;
				end
			end
			ddsp_pkg::MODE_TRI: begin
				total = n * n / 4;
				for (int unsigned i = 1; i < n; i++) begin
					if (i < n / 2)
						acc += i;
					else
						acc += n - i;
					counts[i] = acc;
				end
			end
			// uniform, and the unused code
			default: begin
				total = n;
				for (int unsigned i = 0; i < n; i++)
					counts[i] = i + 1;
			end
		endcase
	endfunction

	function void apply_write(logic [ddsp_pkg::IDX_W-1:0] idx, logic [ddsp_pkg::SIZE_W-1:0] data);
		if (idx == ddsp_pkg::REG_SHAPE_MODE)
			shape = data[ddsp_pkg::MODE_W-1:0];
		else
			size = data;
		rebuild_counts();
	endfunction

	// Leading entries whose count*2^32 is not above u*total
	function logic [ddsp_pkg::DEMAND_W-1:0] demand_for(logic [ddsp_pkg::FRAC_W-1:0] u);
		logic [63:0] scaled;
		int unsigned k;
		scaled = {32'd0, u} * {32'd0, total};
		k = 0;
		while (k < used && scaled >= {counts[k], 32'd0})
			k++;
		return k[ddsp_pkg::DEMAND_W-1:0];
	endfunction

	function void note_fraction(logic [ddsp_pkg::FRAC_W-1:0] u);
		demand_pending_t p;
		p.fraction = u;
		p.demand   = demand_for(u);
		awaited.push_back(p);
		words_in++;
	endfunction

	task report(string msg);
		$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task check_demand(logic [ddsp_pkg::DEMAND_W-1:0] d);
		demand_pending_t p;
		words_out++;
		if (awaited.size() == 0) begin
			report($sformatf("demand %0d arrived with nothing outstanding", d));
		end else begin
			p = awaited.pop_front();
			if (d !== p.demand)
				report($sformatf("u=%h mode=%0d n=%0d: demand %0d, predicted %0d",
					p.fraction, shape, size, d, p.demand));
		end
	endtask

	task drain_check();
		if (awaited.size() != 0)
			report($sformatf("%0d demand words never arrived", awaited.size()));
	endtask
endclass

module discrete_demand_sampler_top_test;
	import ddsp_pkg::*;

	localparam int MAX_ENTRIES  = 128;
	localparam int DRAIN_CYCLES = MAX_ENTRIES + 16;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                tx_valid  = 1'b0;
	logic [FRAC_W-1:0]   tx_word   = '0;
	logic                rx_ready  = 1'b0;
	logic                write_en  = 1'b0;
	logic [IDX_W-1:0]    reg_index = '0;
	logic [SIZE_W-1:0]   write_data = '0;

	logic [15:0]         stall_pattern = 16'hFFFF;
	logic [5:0]          stall_step    = '0;
	int unsigned         burst_left;
	int unsigned         settings_run;

	demand_table_checker sb;

	ddsp_frac_if   frac ();
	ddsp_demand_if demand ();

	assign frac.valid            = tx_valid;
	assign frac.uniform_fraction = tx_word;
	assign demand.ready          = rx_ready;

	discrete_demand_sampler_top #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.frac_in    (frac),
		.demand_out (demand),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: ready follows a rotating stall pattern, reloaded whenever the step counter wraps
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_ready <= 1'b0;
		end else begin
			stall_step <= stall_step + 1'b1;
			if (stall_step == 6'd63)
				stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
					: (16'($urandom) | 16'h0001);
			rx_ready <= stall_pattern[stall_step[3:0]];
		end
	end

	// Demand words are checked at the edge where they are taken
	always @(posedge clk) begin
		if (arst_n && demand.valid === 1'b1 && demand.ready === 1'b1)
			sb.check_demand(demand.demand_value);
	end

	// One fraction word; bursts of random length with random gaps after them
	task send_fraction(input logic [FRAC_W-1:0] u);
		int unsigned gap;
		tx_valid <= 1'b1;
		tx_word  <= u;
		do @(posedge clk); while (frac.ready !== 1'b1);
		sb.note_fraction(u);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				tx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Register write, then hold off until the table rebuild lets words in again
	task write_register(input logic [IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= data;
		@(posedge clk);
		write_en <= 1'b0;
		sb.apply_write(idx, data);
		do @(posedge clk); while (frac.ready !== 1'b1);
	endtask

	// Words at or next to an entry's threshold, spread at random, or at the ends
	function automatic logic [FRAC_W-1:0] pick_fraction();
		logic [63:0] thr;
		int unsigned k;
		case ($urandom_range(0, 9))
			0: return FRAC_W'($urandom_range(0, 3));
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			2, 3, 4, 5: begin
				if (sb.used == 0 || sb.total == 0)
					return $urandom;
				k   = $urandom_range(0, sb.used - 1);
				thr = ({sb.counts[k], 32'd0} + sb.total - 1) / sb.total;
				if (thr > 64'hFFFF_FFFF)
					thr = 64'hFFFF_FFFF;
				case ($urandom_range(0, 2))
					0: if (thr != 0) thr = thr - 1;
					1: if (thr != 64'hFFFF_FFFF) thr = thr + 1;
					default: ;
				endcase
				return thr[FRAC_W-1:0];
			end
			default: return $urandom;
		endcase
	endfunction

	// One table setting: both registers in random order, then a run of words
	task run_setting(input logic [MODE_W-1:0] mode, input logic [SIZE_W-1:0] n,
			input int unsigned count, input bit ends_first);
		if ($urandom_range(0, 1)) begin
			write_register(REG_SHAPE_MODE, SIZE_W'(mode));
			write_register(REG_TABLE_SIZE, n);
		end else begin
			write_register(REG_TABLE_SIZE, n);
			write_register(REG_SHAPE_MODE, SIZE_W'(mode));
		end
		if (ends_first) begin
			send_fraction(32'h0000_0000);
			send_fraction(32'hFFFF_FFFF);
		end
		repeat (count) send_fraction(pick_fraction());
		tx_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		settings_run++;
	endtask

	initial begin
		sb = new();
		burst_left = 1;
		settings_run = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (frac.ready !== 1'b1);

		// reset table: uniform over 100 entries
		send_fraction(32'h0000_0000);
		send_fraction(32'hFFFF_FFFF);
		send_fraction(32'h8000_0000);
		repeat (100) send_fraction(pick_fraction());
		tx_valid <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		settings_run++;

		// small ramp, odd and size-one triangles, unused mode,
		// empty table, full and saturated sizes
		run_setting(MODE_RAMP, 8'd2, 50, 1'b1);
		run_setting(MODE_TRI, 8'd7, 50, 1'b1);
		run_setting(MODE_TRI, 8'd1, 50, 1'b1);
		run_setting(MODE_UNUSED, 8'd5, 50, 1'b1);
		run_setting(MODE_UNIFORM, 8'd0, 50, 1'b1);
		run_setting(MODE_TRI, 8'd128, 50, 1'b1);
		run_setting(MODE_RAMP, 8'd255, 50, 1'b1);
		run_setting(MODE_UNIFORM, 8'd200, 50, 1'b1);
		run_setting(MODE_TRI, 8'd2, 50, 1'b1);
		run_setting(MODE_RAMP, 8'd16, 50, 1'b1);
		run_setting(MODE_TRI, 8'd33, 50, 1'b0);

		// random settings, sizes mostly small
		repeat (6) begin
			run_setting(MODE_W'($urandom_range(0, 3)),
				($urandom_range(0, 3) != 0) ? SIZE_W'($urandom_range(2, 40))
					: SIZE_W'($urandom_range(0, 255)),
				100, 1'b0);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.drain_check();
		$display("Covered %0d fraction words over %0d table settings (all shapes, sizes 0 to 255);",
			sb.words_in, settings_run);
		$display("%0d demand words checked against the table predictor, %0d mismatches.",
			sb.words_out, sb.mismatches);
		if (sb.mismatches == 0)
			$display("discrete_demand_sampler_top_test passed");
		else
			$display("discrete_demand_sampler_top_test failed");
		$finish;
	end

	// Watchdog, several times the slowest correct run
	initial begin
		#40_000_000;
		$display("discrete_demand_sampler_top_test failed");
		$finish;
	end
endmodule
`default_nettype wire
